[sv/ddf_pkg.sv]
package ddf_pkg;

  localparam int NUM_DIGITS  = 10;
  localparam int NUM_BITS    = 32;
  localparam int NUM_STAGES  = 4;
  localparam int STAGE_STEPS = NUM_BITS / NUM_STAGES;

  localparam logic [1:0] FMT_TEN   = 2'd0;
  localparam logic [1:0] FMT_FIVE  = 2'd1;
  localparam logic [1:0] FMT_THREE = 2'd2;
  localparam logic [1:0] FMT_FREQ  = 2'd3;

  localparam logic [6:0] ASCII_ZERO  = 7'd48;
  localparam logic [6:0] ASCII_POINT = 7'd46;
  localparam logic [6:0] ASCII_BLANK = 7'd32;

  typedef struct packed {
    logic [1:0]  func;
    logic [2:0]  row;
    logic [5:0]  col;
    logic [31:0] number;
  } req_t;

  typedef struct packed {
    logic [6:0] char_code;
    logic [2:0] out_row;
    logic [6:0] out_col;
    logic       last;
  } chr_t;

  // Conversion in flight: binary bits still to shift, BCD digits built so far.
  typedef struct packed {
    logic [1:0]                  func;
    logic [2:0]                  row;
    logic [5:0]                  col;
    logic [NUM_BITS-1:0]         bin;
    logic [4*NUM_DIGITS-1:0]     bcd;
  } conv_t;

endpackage

[sv/ddf_dabble_stage.sv]
module ddf_dabble_stage (
  input  logic          clk,
  input  logic          rst,
  input  logic          up_valid,
  output logic          up_stall,
  input  ddf_pkg::conv_t up,
  output logic          dn_valid,
  input  logic          dn_stall,
  output ddf_pkg::conv_t dn
);
  import ddf_pkg::*;

  conv_t step;
  logic  advance;

  // Run STAGE_STEPS rounds of add-3-then-shift.
  always_comb begin
    int s;
    int d;
    step = up;
    for (s = 0; s < STAGE_STEPS; s++) begin
      for (d = 0; d < NUM_DIGITS; d++) begin
        if (step.bcd[4*d +: 4] >= 4'd5) begin
          step.bcd[4*d +: 4] = step.bcd[4*d +: 4] + 4'd3;
        end
      end
      {step.bcd, step.bin} = {step.bcd[4*NUM_DIGITS-2:0], step.bin, 1'b0};
    end
  end

  assign advance  = !dn_valid || !dn_stall;
  assign up_stall = !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (advance) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && up_valid) begin
      dn <= step;
    end
  end

endmodule

[sv/ddf_serializer.sv]
module ddf_serializer (
  input  logic           clk,
  input  logic           rst,
  input  logic           cv_valid,
  output logic           cv_stall,
  input  ddf_pkg::conv_t cv,
  output logic           chr_valid,
  input  logic           chr_stall,
  output ddf_pkg::chr_t  chr
);
  import ddf_pkg::*;

  logic                    busy;
  logic [3:0]              idx;
  logic [1:0]              fmt;
  logic [2:0]              row;
  logic [5:0]              col;
  logic [4*NUM_DIGITS-1:0] digits;

  logic [3:0] count;
  logic [3:0] dsel;
  logic [3:0] digit;
  logic [3:0] offset;
  logic       is_last;
  logic       load_out;
  logic       emit;
  logic       done;
  logic       take;
  chr_t       chr_next;

  always_comb begin
    unique case (fmt)
      FMT_TEN:   count = 4'd10;
      FMT_FIVE:  count = 4'd5;
      FMT_THREE: count = 4'd3;
      FMT_FREQ:  count = 4'd7;
      default:   count = 4'd10;
    endcase
  end

  // Frequency form puts a point third from the right; skip it in the digit index.
  always_comb begin
    dsel    = ((fmt == FMT_FREQ) && (idx >= 4'd3)) ? idx - 4'd1 : idx;
    digit   = digits[4*dsel +: 4];
    offset  = count - 4'd1 - idx;
    is_last = (idx == count - 4'd1);

    chr_next.char_code = ASCII_ZERO + {3'b000, digit};
    if (fmt == FMT_FREQ && idx == 4'd2) begin
      chr_next.char_code = ASCII_POINT;
    end else if (fmt == FMT_FREQ && is_last && digit == 4'd0) begin
      chr_next.char_code = ASCII_BLANK;
    end
    chr_next.out_row = row;
    chr_next.out_col = {1'b0, col} + {3'b000, offset};
    chr_next.last    = is_last;
  end

  assign load_out = !chr_valid || !chr_stall;
  assign emit     = busy && load_out;
  assign done     = emit && is_last;
  assign cv_stall = busy && !done;
  assign take     = cv_valid && !cv_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      idx       <= 4'd0;
      chr_valid <= 1'b0;
    end else begin
      if (load_out) begin
        chr_valid <= emit;
      end
      if (take) begin
        busy <= 1'b1;
        idx  <= 4'd0;
      end else begin
        if (done) begin
          busy <= 1'b0;
        end
        if (emit) begin
          idx <= idx + 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      chr <= chr_next;
    end
    if (take) begin
      fmt    <= cv.func;
      row    <= cv.row;
      col    <= cv.col;
      digits <= cv.bcd;
    end
  end

endmodule

[sv/decimal_digit_display_formatter.sv]
// Channel | Direction | Handshake            | Payload
// req     | in        | req_valid, req_stall | ddf_pkg::req_t (func, row, col, number)
// chr     | out       | chr_valid, chr_stall | ddf_pkg::chr_t (char_code, out_row, out_col, last)
//
// A number passes four binary-to-BCD stages of eight shift steps each; one may enter per
// cycle unless a stall backs up to req. The character serializer sends 10, 5, 3 or 7
// characters (format 0..3) at one per cycle while chr is not stalled; it takes the next
// conversion as it sends the last character of the current one.
// Reset (rst, synchronous) clears all valid bits; payload registers are not reset.
// A stall on chr holds the output and backs up through the stages without loss.
module decimal_digit_display_formatter (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  ddf_pkg::req_t  req,
  output logic           chr_valid,
  input  logic           chr_stall,
  output ddf_pkg::chr_t  chr
);
  import ddf_pkg::*;

  logic  valid [NUM_STAGES+1];
  logic  stall [NUM_STAGES+1];
  conv_t conv  [NUM_STAGES+1];

  always_comb begin
    conv[0].func = req.func;
    conv[0].row  = req.row;
    conv[0].col  = req.col;
    conv[0].bin  = (req.func == FMT_THREE) ? {16'h0000, req.number[15:0]} : req.number;
    conv[0].bcd  = '0;
  end

  assign valid[0]  = req_valid;
  assign req_stall = stall[0];

  for (genvar g = 0; g < NUM_STAGES; g++) begin : g_stage
    ddf_dabble_stage u_stage (
      .clk      (clk),
      .rst      (rst),
      .up_valid (valid[g]),
      .up_stall (stall[g]),
      .up       (conv[g]),
      .dn_valid (valid[g+1]),
      .dn_stall (stall[g+1]),
      .dn       (conv[g+1])
    );
  end

  ddf_serializer u_ser (
    .clk       (clk),
    .rst       (rst),
    .cv_valid  (valid[NUM_STAGES]),
    .cv_stall  (stall[NUM_STAGES]),
    .cv        (conv[NUM_STAGES]),
    .chr_valid (chr_valid),
    .chr_stall (chr_stall),
    .chr       (chr)
  );

endmodule

[sv/ddf_checker.sv]
module ddf_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_stall,
  input logic          chr_valid,
  input logic          chr_stall,
  input ddf_pkg::chr_t chr
);
  import ddf_pkg::*;

  // Nothing comes out right after reset.
  a_reset_quiet: assert property (@(posedge clk) rst |=> !chr_valid)
    else $error("output valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    chr_valid && chr_stall |=> chr_valid && $stable(chr))
    else $error("stalled character changed");

  // Within a run the characters follow back to back, one column to the left.
  a_run_cont: assert property (@(posedge clk) disable iff (rst)
    chr_valid && !chr_stall && !chr.last |=>
      chr_valid && chr.out_col == $past(chr.out_col) - 7'd1 && chr.out_row == $past(chr.out_row))
    else $error("run broken or column out of order");

  // The leftmost character of a run sits at a column the request could name.
  a_last_col: assert property (@(posedge clk) disable iff (rst)
    chr_valid && chr.last |-> chr.out_col[6] == 1'b0)
    else $error("last character beyond start column range");

  // An idle request port sees no stall while nothing is in flight after reset.
  a_ready_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !req_stall)
    else $error("request stalled right after reset");

endmodule

bind decimal_digit_display_formatter ddf_checker u_ddf_checker (
  .clk       (clk),
  .rst       (rst),
  .req_stall (req_stall),
  .chr_valid (chr_valid),
  .chr_stall (chr_stall),
  .chr       (chr)
);

[tb/ddf_char_checker.sv]
module ddf_char_checker (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  input  logic           req_stall,
  input  ddf_pkg::req_t  req,
  input  logic           chr_valid,
  input  logic           chr_stall,
  input  ddf_pkg::chr_t  chr,
  output int             fails,
  output int             pending
);
  import ddf_pkg::*;

  chr_t expected_chars[$];

  function automatic chr_t make_char(logic [6:0] code, req_t r, int offset, bit is_last);
    chr_t c;
    c.char_code = code;
    c.out_row   = r.row;
    c.out_col   = {1'b0, r.col} + 7'(offset);
    c.last      = is_last;
    return c;
  endfunction

  function automatic logic [6:0] digit_char(logic [31:0] value, logic [31:0] scale);
    return ASCII_ZERO + 7'((value / scale) % 10);
  endfunction

  // Queue the characters of one request, rightmost position first.
  task automatic predict_chars(req_t r);
    logic [31:0] value;
    logic [31:0] scale;
    logic [3:0]  top;
    int          width;
    if (r.func == FMT_FREQ) begin
      top = 4'((r.number / 100000) % 10);
      expected_chars.push_back(make_char(digit_char(r.number, 1), r, 6, 1'b0));
      expected_chars.push_back(make_char(digit_char(r.number, 10), r, 5, 1'b0));
      expected_chars.push_back(make_char(ASCII_POINT, r, 4, 1'b0));
      expected_chars.push_back(make_char(digit_char(r.number, 100), r, 3, 1'b0));
      expected_chars.push_back(make_char(digit_char(r.number, 1000), r, 2, 1'b0));
      expected_chars.push_back(make_char(digit_char(r.number, 10000), r, 1, 1'b0));
      // blank the leading digit when it is zero
      expected_chars.push_back(make_char((top == 0) ? ASCII_BLANK : ASCII_ZERO + 7'(top),
                                         r, 0, 1'b1));
    end else begin
      case (r.func)
        FMT_TEN:  width = 10;
        FMT_FIVE: width = 5;
        default:  width = 3;
      endcase
      value = (r.func == FMT_THREE) ? {16'd0, r.number[15:0]} : r.number;
      scale = 1;
      for (int i = 0; i < width; i++) begin
        expected_chars.push_back(make_char(digit_char(value, scale), r, width - 1 - i,
                                           (width - 1 - i) == 0));
        scale = scale * 10;
      end
    end
  endtask

  always @(posedge clk) begin
    chr_t want;
    if (rst) begin
      fails   = 0;
      pending <= 0;
    end else begin
      if (req_valid && !req_stall)
        predict_chars(req);
      if (chr_valid && !chr_stall) begin
        if (expected_chars.size() == 0) begin
          $display("%0t: unexpected char: code %0d row %0d col %0d last %0d", $time,
                   chr.char_code, chr.out_row, chr.out_col, chr.last);
          fails = fails + 1;
        end else begin
          want = expected_chars.pop_front();
          if (chr.char_code !== want.char_code || chr.out_row !== want.out_row ||
              chr.out_col !== want.out_col || chr.last !== want.last) begin
            $display({"%0t: char mismatch: expected code %0d row %0d col %0d last %0d, ",
                      "got code %0d row %0d col %0d last %0d"},
                     $time, want.char_code, want.out_row, want.out_col, want.last,
                     chr.char_code, chr.out_row, chr.out_col, chr.last);
            fails = fails + 1;
          end
        end
      end
      pending <= expected_chars.size();
    end
  end

endmodule

[tb/tb.sv]
module tb;
  import ddf_pkg::*;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req       = '0;
  logic chr_valid;
  logic chr_stall = 1'b0;
  chr_t chr;
  int   fails;
  int   pending;

  always #10 clk = ~clk;

  decimal_digit_display_formatter DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .chr_valid (chr_valid),
    .chr_stall (chr_stall),
    .chr       (chr)
  );

  ddf_char_checker checker_inst (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .chr_valid (chr_valid),
    .chr_stall (chr_stall),
    .chr       (chr),
    .fails     (fails),
    .pending   (pending)
  );

  // Mostly back-to-back, some short pauses, a few long ones.
  function automatic int idle_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic req_t make_req(logic [1:0] func, logic [2:0] row, logic [5:0] col,
                                    logic [31:0] number);
    req_t r;
    r.func   = func;
    r.row    = row;
    r.col    = col;
    r.number = number;
    return r;
  endfunction

  function automatic logic [31:0] random_number();
    logic [31:0] scale;
    int          k;
    case ($urandom_range(0, 5))
      0, 1: return $urandom;
      2: return $urandom_range(0, 999);
      3: return $urandom_range(0, 1999999);
      4: begin
        // land next to a power of ten
        k = $urandom_range(1, 9);
        scale = 1;
        for (int i = 0; i < k; i++) scale = scale * 10;
        return scale + $urandom_range(0, 4) - 2;
      end
      default: return {16'($urandom_range(0, 65535)), 16'd0} |
                      32'($urandom_range(65530, 65535));
    endcase
  endfunction

  task automatic send_req(req_t r);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  // Output back-pressure: free runs of varied length, then stall bursts.
  initial begin
    int free_len;
    int hold_len;
    @(negedge rst);
    forever begin
      free_len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 6);
      repeat (free_len) @(posedge clk);
      chr_stall <= 1'b1;
      hold_len = idle_len() + 1;
      repeat (hold_len) @(posedge clk);
      chr_stall <= 1'b0;
    end
  end

  initial begin
    req_t directed[$];
    directed.push_back(make_req(FMT_TEN,   3'd0, 6'd0,  32'd0));
    directed.push_back(make_req(FMT_TEN,   3'd7, 6'd63, 32'hFFFF_FFFF));
    directed.push_back(make_req(FMT_TEN,   3'd1, 6'd5,  32'd1000000000));
    directed.push_back(make_req(FMT_TEN,   3'd3, 6'd10, 32'd4000000000));
    directed.push_back(make_req(FMT_TEN,   3'd5, 6'd21, 32'd1234567890));
    directed.push_back(make_req(FMT_TEN,   3'd2, 6'd42, 32'hAAAA_AAAA));
    directed.push_back(make_req(FMT_TEN,   3'd5, 6'd21, 32'h5555_5555));
    directed.push_back(make_req(FMT_FIVE,  3'd0, 6'd0,  32'd99999));
    directed.push_back(make_req(FMT_FIVE,  3'd4, 6'd30, 32'd100000));
    directed.push_back(make_req(FMT_FIVE,  3'd7, 6'd63, 32'hFFFF_FFFF));
    directed.push_back(make_req(FMT_THREE, 3'd6, 6'd1,  32'd65535));
    directed.push_back(make_req(FMT_THREE, 3'd2, 6'd7,  32'd65536));
    directed.push_back(make_req(FMT_THREE, 3'd1, 6'd12, 32'd999));
    directed.push_back(make_req(FMT_THREE, 3'd7, 6'd63, 32'hFFFF_FFFF));
    directed.push_back(make_req(FMT_FREQ,  3'd0, 6'd0,  32'd0));
    directed.push_back(make_req(FMT_FREQ,  3'd3, 6'd9,  32'd99999));
    directed.push_back(make_req(FMT_FREQ,  3'd4, 6'd17, 32'd100000));
    directed.push_back(make_req(FMT_FREQ,  3'd5, 6'd33, 32'd999999));
    directed.push_back(make_req(FMT_FREQ,  3'd6, 6'd50, 32'd1000000));
    directed.push_back(make_req(FMT_FREQ,  3'd7, 6'd63, 32'hFFFF_FFFF));

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) send_req(directed[i]);
    repeat (240) send_req(make_req(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                                   6'($urandom_range(0, 63)), random_number()));
    req_valid <= 1'b0;

    // let the count catch up with the last request, drain, then watch for stray characters
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fails == 0 && pending == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  initial begin
    #(20 * 400000);
    $display("Test completed with failures");
    $finish;
  end

endmodule

[decimal_digit_display_formatter.f]
sv/ddf_pkg.sv
sv/ddf_dabble_stage.sv
sv/ddf_serializer.sv
sv/decimal_digit_display_formatter.sv
sv/ddf_checker.sv
tb/ddf_char_checker.sv
tb/tb.sv
